[hdl/svm_pkg.sv]
`timescale 1ns / 1ps
package svm_pkg;

	localparam int VOICES_DEF = 8;
	localparam int SAMPLE_DEPTH_DEF = 4096;
	localparam logic [15:0] GAIN_ONE = 16'h8000;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_PLAY = 2'd1,
		CMD_MIX  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [11:0]        addr;
		logic signed [15:0] sample_value;
		logic [12:0]        length;
		logic [15:0]        gain_left;
		logic [15:0]        gain_right;
		logic signed [15:0] music_left;
		logic signed [15:0] music_right;
	} req_t;

	typedef struct packed {
		logic signed [15:0] mix_left;
		logic signed [15:0] mix_right;
		logic               status;
		logic [2:0]         voice_slot;
		logic [7:0]         active_voices;
	} rsp_t;

	function automatic logic [15:0] clamp_gain(input logic [15:0] g);
		return (g > GAIN_ONE) ? GAIN_ONE : g;
	endfunction

	function automatic logic signed [15:0] round_sat(input logic signed [39:0] acc);
		logic signed [39:0] v;
		logic signed [24:0] q;
		v = acc + 40'sd16384;
		q = v[39:15];
		if (q > 25'sd32767)
			return 16'sh7fff;
		else if (q < -25'sd32768)
			return 16'sh8000;
		else
			return q[15:0];
	endfunction

endpackage

[hdl/svm_queue.sv]
`timescale 1ns / 1ps
module svm_queue
	import svm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  req_t wr_data,
	output logic rd_valid,
	input  logic rd_take,
	output req_t rd_data
);

	req_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && !wr_stall)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && !wr_stall)
				wp_q <= ~wp_q;
			if (rd_take)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && !wr_stall) - 2'(rd_take);
		end
	end

endmodule

[hdl/svm_engine.sv]
`timescale 1ns / 1ps
module svm_engine
	import svm_pkg::*;
#(
	parameter int VOICES       = VOICES_DEF,
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_take,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	logic signed [15:0] sram [SAMPLE_DEPTH];
	logic signed [15:0] rdata_q;
	logic [AW-1:0]      raddr;
	logic               rd_en;

	state_t             state_q;
	logic [VOICES-1:0]  active_q;
	logic [11:0]        start_q [VOICES];
	logic [12:0]        len_q   [VOICES];
	logic [12:0]        pos_q   [VOICES];
	logic [15:0]        gl_q    [VOICES];
	logic [15:0]        gr_q    [VOICES];
	logic [VW-1:0]      v_q;
	logic signed [39:0] accl_q;
	logic signed [39:0] accr_q;
	logic signed [32:0] pl_q;
	logic signed [32:0] pr_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	logic [VW-1:0]      free_idx;
	logic               free_found;
	logic [13:0]        sum_addr;
	logic               rsp_load;

	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx   = VW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign sum_addr = 14'(start_q[v_q]) + 14'(pos_q[v_q]);
	assign raddr    = AW'(sum_addr);
	assign rd_en    = (state_q == ST_ADDR);
	assign req_take = (state_q == ST_IDLE) && req_valid && !(rsp_valid_q && rsp_stall);
	assign rsp_load = (req_take && cmd_t'(req.cmd) != CMD_MIX) ||
		(state_q == ST_DONE && !(rsp_valid_q && rsp_stall));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (req_take && cmd_t'(req.cmd) == CMD_LOAD)
			sram[AW'(req.addr)] <= req.sample_value;
		if (rd_en)
			rdata_q <= sram[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
			v_q         <= '0;
			for (int i = 0; i < VOICES; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
				pos_q[i]   <= '0;
				gl_q[i]    <= '0;
				gr_q[i]    <= '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall && !rsp_load)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						unique case (cmd_t'(req.cmd))
							CMD_PLAY: begin
								if (free_found) begin
									start_q[free_idx] <= req.addr;
									len_q[free_idx]   <= req.length;
									pos_q[free_idx]   <= '0;
									gl_q[free_idx]    <= clamp_gain(req.gain_left);
									gr_q[free_idx]    <= clamp_gain(req.gain_right);
									active_q[free_idx] <= 1'b1;
									rsp_q <= '{mix_left: 16'sd0, mix_right: 16'sd0,
										status: 1'b0, voice_slot: 3'(free_idx),
										active_voices: 8'(active_q | (VOICES'(1) << free_idx))};
								end else begin
									rsp_q <= '{mix_left: 16'sd0, mix_right: 16'sd0,
										status: 1'b1, voice_slot: 3'd0,
										active_voices: 8'(active_q)};
								end
								rsp_valid_q <= 1'b1;
							end
							CMD_MIX: begin
								accl_q  <= 40'(req.music_left) <<< 15;
								accr_q  <= 40'(req.music_right) <<< 15;
								v_q     <= '0;
								state_q <= ST_ADDR;
							end
							CMD_LOAD, CMD_NONE: begin
								rsp_q <= '{mix_left: 16'sd0, mix_right: 16'sd0,
									status: 1'b0, voice_slot: 3'd0,
									active_voices: 8'(active_q)};
								rsp_valid_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_ADDR: begin
					if (!active_q[v_q] || pos_q[v_q] >= len_q[v_q]) begin
						active_q[v_q] <= 1'b0;
						if (32'(v_q) == VOICES - 1)
							state_q <= ST_DONE;
						else
							v_q <= v_q + 1'b1;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					pl_q    <= rdata_q * $signed({1'b0, gl_q[v_q]});
					pr_q    <= rdata_q * $signed({1'b0, gr_q[v_q]});
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					accl_q <= accl_q + 40'(pl_q);
					accr_q <= accr_q + 40'(pr_q);
					pos_q[v_q] <= pos_q[v_q] + 13'd1;
					if (pos_q[v_q] + 13'd1 >= len_q[v_q])
						active_q[v_q] <= 1'b0;
					if (32'(v_q) == VOICES - 1)
						state_q <= ST_DONE;
					else begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_ADDR;
					end
				end
				ST_DONE: begin
					if (!(rsp_valid_q && rsp_stall)) begin
						rsp_q <= '{mix_left: round_sat(accl_q),
							mix_right: round_sat(accr_q), status: 1'b0,
							voice_slot: 3'd0, active_voices: 8'(active_q)};
						rsp_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/sample_voice_mixer.sv]
`timescale 1ns / 1ps
// Eight-voice sample mixer. Requests enter a two-entry queue that is free
// whenever it has room; a sequencer behind it runs them. Load and play are
// answered from the idle state; a mix is one shared pass over the voices:
// memory read, one multiply pair, accumulate, three steps for each playing
// voice and one for each idle one. Samples read before being loaded give
// undefined mix values.
module sample_voice_mixer
	import svm_pkg::*;
#(
	parameter int VOICES       = VOICES_DEF,
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	localparam logic [7:0] VMASK = (VOICES >= 8) ? 8'hff : 8'((1 << VOICES) - 1);

	logic q_valid;
	logic q_take;
	req_t q_data;

	svm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_stall (in_stall),
		.wr_data  (in_data),
		.rd_valid (q_valid),
		.rd_take  (q_take),
		.rd_data  (q_data)
	);

	svm_engine #(
		.VOICES       (VOICES),
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (q_valid),
		.req_take  (q_take),
		.req       (q_data),
		.rsp_valid (out_valid),
		.rsp_stall (out_stall),
		.rsp       (out_data)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("queue read while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.voice_slot == 3'd0)
		else $error("slot given on dropped play");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> (out_data.active_voices & VMASK) == VMASK)
		else $error("play dropped with a free voice");

endmodule

[sim/sample_voice_mixer_tb.sv]
`timescale 1ns / 1ps
module sample_voice_mixer_tb;
	import svm_pkg::*;

	localparam int NVOICE = 8;
	localparam int DEPTH = 4096;
	localparam int ITEMS = 1600;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	sample_voice_mixer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor state
	logic signed [15:0] mem_model [DEPTH];
	logic [7:0]         busy_mask;
	logic [11:0]        v_start [NVOICE];
	logic [12:0]        v_len [NVOICE];
	logic [12:0]        v_pos [NVOICE];
	logic [15:0]        v_gl [NVOICE];
	logic [15:0]        v_gr [NVOICE];

	// generator shadow, used to keep voices on written memory
	bit         gen_written [DEPTH];

	req_t pending_reqs [$];
	rsp_t expected_frames [$];
	int   errors = 0;
	int   pushed = 0;
	bit   hold_sender = 0;
	bit   long_hold = 0;

	function automatic logic [15:0] sat_gain(logic [15:0] g);
		return (g > 16'h8000) ? 16'h8000 : g;
	endfunction

	function automatic logic signed [15:0] round_to_q15(longint acc);
		longint v, q;
		v = acc + 16384;
		q = v >>> 15;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic rsp_t predict_frame(req_t r);
		rsp_t o;
		longint al, ar, s;
		int slot;
		logic [11:0] a;
		o = '0;
		case (cmd_t'(r.cmd))
		CMD_LOAD: begin
			mem_model[r.addr] = r.sample_value;
		end
		CMD_PLAY: begin
			slot = -1;
			for (int i = 0; i < NVOICE; i++)
				if (slot < 0 && !busy_mask[i]) slot = i;
			if (slot < 0) begin
				o.status = 1'b1;
			end else begin
				v_start[slot] = r.addr;
				v_len[slot] = r.length;
				v_pos[slot] = '0;
				v_gl[slot] = sat_gain(r.gain_left);
				v_gr[slot] = sat_gain(r.gain_right);
				busy_mask[slot] = 1'b1;
				o.voice_slot = slot[2:0];
			end
		end
		CMD_MIX: begin
			al = longint'(r.music_left) * 32768;
			ar = longint'(r.music_right) * 32768;
			for (int i = 0; i < NVOICE; i++) begin
				if (busy_mask[i]) begin
					if (v_pos[i] < v_len[i]) begin
						a = v_start[i] + v_pos[i][11:0];
						s = longint'(mem_model[a]);
						al += s * longint'(v_gl[i]);
						ar += s * longint'(v_gr[i]);
						v_pos[i] = v_pos[i] + 13'd1;
					end
					if (v_pos[i] >= v_len[i]) busy_mask[i] = 1'b0;
				end
			end
			o.mix_left = round_to_q15(al);
			o.mix_right = round_to_q15(ar);
		end
		default: ;
		endcase
		o.active_voices = busy_mask;
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// stimulus helpers
	function automatic req_t make_req(cmd_t c);
		req_t r;
		r = '0;
		r.cmd = c;
		r.addr = 12'($urandom());
		r.sample_value = 16'($urandom());
		r.length = 13'($urandom());
		r.gain_left = 16'($urandom());
		r.gain_right = 16'($urandom());
		r.music_left = 16'($urandom());
		r.music_right = 16'($urandom());
		return r;
	endfunction

	task automatic push_load(logic [11:0] a, logic [15:0] v);
		req_t r;
		r = make_req(CMD_LOAD);
		r.addr = a;
		r.sample_value = v;
		gen_written[a] = 1'b1;
		pending_reqs.push_back(r);
		pushed++;
	endtask

	// play only over written memory, so no unwritten entry is ever read;
	// a voice reads no more entries than mixes can still follow it
	task automatic push_play(logic [11:0] a, logic [12:0] n, logic [15:0] gl,
			logic [15:0] gr);
		req_t r;
		int lim;
		lim = (int'(n) < ITEMS - pushed) ? int'(n) : ITEMS - pushed;
		for (int k = 0; k < lim; k++)
			if (!gen_written[(a + k) % DEPTH])
				push_load(12'((a + k) % DEPTH), 16'($urandom()));
		r = make_req(CMD_PLAY);
		r.addr = a;
		r.length = n;
		r.gain_left = gl;
		r.gain_right = gr;
		pending_reqs.push_back(r);
		pushed++;
	endtask

	task automatic push_mix(logic [15:0] l, logic [15:0] rr);
		req_t r;
		r = make_req(CMD_MIX);
		r.music_left = l;
		r.music_right = rr;
		pending_reqs.push_back(r);
		pushed++;
	endtask

	task automatic push_none();
		pending_reqs.push_back(make_req(CMD_NONE));
		pushed++;
	endtask

	function automatic logic [15:0] rand_gain();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 16'h8000;
		if (p == 1) return 16'($urandom_range(16'h8001, 16'hffff));
		if (p == 2) return 16'h0000;
		return 16'($urandom());
	endfunction

	function automatic logic [12:0] rand_len(bit allow_long);
		int p;
		p = $urandom_range(0, 19);
		if (p == 0) return 13'd0;
		if (p == 1 && allow_long) return 13'($urandom_range(4097, 8191));
		return 13'($urandom_range(1, 12));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				expected_frames.push_back(predict_frame(in_data));
				send_gap = gap_len();
			end
			if (send_gap > 0 || hold_sender || pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
				if (send_gap > 0) send_gap--;
			end else begin
				in_valid <= 1'b1;
				in_data <= pending_reqs.pop_front();
			end
		end
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result with nothing expected: %p", out_data);
					errors++;
				end else begin
					e = expected_frames.pop_front();
					if (out_data.mix_left !== e.mix_left) begin
						$error("mix_left exp %0d got %0d", e.mix_left, out_data.mix_left);
						errors++;
					end
					if (out_data.mix_right !== e.mix_right) begin
						$error("mix_right exp %0d got %0d", e.mix_right, out_data.mix_right);
						errors++;
					end
					if (out_data.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_data.status);
						errors++;
					end
					if (out_data.voice_slot !== e.voice_slot) begin
						$error("voice_slot exp %0d got %0d", e.voice_slot, out_data.voice_slot);
						errors++;
					end
					if (out_data.active_voices !== e.active_voices) begin
						$error("active_voices exp %h got %h", e.active_voices,
							out_data.active_voices);
						errors++;
					end
				end
			end
			if (long_hold) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else begin
				recv_gap = gap_len();
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int wait_cycles;
		bit hold_off_done, pause_done;
		hold_off_done = 1'b0;
		pause_done = 1'b0;
		busy_mask = '0;
		for (int i = 0; i < NVOICE; i++) begin
			v_start[i] = '0; v_len[i] = '0; v_pos[i] = '0; v_gl[i] = '0; v_gr[i] = '0;
		end
		for (int i = 0; i < DEPTH; i++) begin
			mem_model[i] = '0;
			gen_written[i] = 1'b0;
		end

		// directed: extremes, wrap, zero length, gain clamp, busy drop, unused command
		push_load(12'hfff, 16'sh7fff);
		push_load(12'h000, 16'sh8000);
		push_load(12'h001, 16'hffff);
		push_play(12'hffe, 13'd3, 16'h8000, 16'hffff);
		push_play(12'h000, 13'd0, 16'h0000, 16'h8000);
		push_mix(16'sh7fff, 16'sh8000);
		push_mix(16'sh8000, 16'sh7fff);
		push_mix(16'h0000, 16'hffff);
		for (int i = 0; i < 9; i++) push_play(12'h000, 13'd2, 16'h8000, 16'h8000);
		push_mix(16'sh7fff, 16'sh7fff);
		push_none();
		push_mix(16'sh8000, 16'sh8000);
		push_mix(16'h0000, 16'h0000);

		// random: mostly play/mix traffic over loaded memory
		while (pushed < ITEMS) begin
			int p;
			p = $urandom_range(0, 99);
			if (p < 20) begin
				push_load(12'($urandom()), 16'($urandom()));
			end else if (p < 40) begin
				push_play(12'($urandom()), rand_len(ITEMS - pushed <= 40), rand_gain(),
					rand_gain());
			end else if (p < 97) begin
				push_mix(16'($urandom()), 16'($urandom()));
			end else begin
				push_none();
			end
			if (!hold_off_done && pushed >= ITEMS / 4) begin
				// long receiver hold-off while the sender keeps offering
				hold_off_done = 1'b1;
				while (pending_reqs.size() >= 50) @(posedge clk);
				long_hold = 1'b1;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end
			if (!pause_done && pushed >= ITEMS / 2) begin
				// sender pause until everything has drained
				pause_done = 1'b1;
				while (pending_reqs.size() != 0) @(posedge clk);
				hold_sender = 1'b1;
				@(posedge clk);
				while (in_valid || expected_frames.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
		end

		while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
		wait_cycles = 0;
		while (expected_frames.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_frames.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
hdl/svm_pkg.sv
hdl/svm_queue.sv
hdl/svm_engine.sv
hdl/sample_voice_mixer.sv
sim/sample_voice_mixer_tb.sv
